>>> rtl/core/aes256_block_cipher_core_defines.svh
// Assertion macros shared by the cipher core RTL.
`ifndef AES256_BLOCK_CIPHER_CORE_DEFINES_SVH
`define AES256_BLOCK_CIPHER_CORE_DEFINES_SVH

// Implication checked on every rising edge, off while reset is held.
`define AES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same, but also checked while reset is held.
`define AES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumKeys   = NumRounds + 1;
  localparam int unsigned KeyIdxW   = $clog2(NumKeys);

  typedef logic [127:0] blk_t;

  // Key expansion status toward the datapath
  typedef struct packed {
    logic busy;
    logic done;
  } kx_status_t;

  // Configuration register indexes
  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;

  // Request types
  localparam logic ReqEncrypt = 1'b0;
  localparam logic ReqDecrypt = 1'b1;

  localparam logic [7:0] GfPoly = 8'h1b;
  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] SBOX_REV [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
  endfunction

  // GF(2^8) product, one shift-and-add step per multiplier bit
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] aa;
    p  = 8'h00;
    aa = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ aa;
      aa = xtime(aa);
    end
    return p;
  endfunction

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8]; i = 4*column + row
  function automatic logic [7:0] get_byte(blk_t s, int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic blk_t sub_shift(blk_t s, logic inv);
    blk_t t;
    int unsigned src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? unsigned'((c - r + 4) % 4) : unsigned'((c + r) % 4);
        t[127-8*(4*c+r) -: 8] = inv ? SBOX_REV[get_byte(s, 4*src + r)]
                                    : SBOX[get_byte(s, 4*src + r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t col_mix(blk_t s, logic inv);
    blk_t t;
    logic [7:0] m0, m1, m2, m3;
    logic [7:0] a, b, d, e;
    t  = '0;
    m0 = inv ? 8'h0e : 8'h02;
    m1 = inv ? 8'h0b : 8'h03;
    m2 = inv ? 8'h0d : 8'h01;
    m3 = inv ? 8'h09 : 8'h01;
    for (int c = 0; c < 4; c++) begin
      a = get_byte(s, 4*c);
      b = get_byte(s, 4*c+1);
      d = get_byte(s, 4*c+2);
      e = get_byte(s, 4*c+3);
      t[127-32*c -: 8]  = gf_mul(a, m0) ^ gf_mul(b, m1) ^ gf_mul(d, m2) ^ gf_mul(e, m3);
      t[119-32*c -: 8]  = gf_mul(a, m3) ^ gf_mul(b, m0) ^ gf_mul(d, m1) ^ gf_mul(e, m2);
      t[111-32*c -: 8]  = gf_mul(a, m2) ^ gf_mul(b, m3) ^ gf_mul(d, m0) ^ gf_mul(e, m1);
      t[103-32*c -: 8]  = gf_mul(a, m1) ^ gf_mul(b, m2) ^ gf_mul(d, m3) ^ gf_mul(e, m0);
    end
    return t;
  endfunction

  // One cipher round; the final round skips the column mix
  function automatic blk_t cipher_round(blk_t s, blk_t rk, logic inv, logic last);
    blk_t t;
    t = sub_shift(s, inv);
    if (!last) t = col_mix(t, inv);
    return t ^ rk;
  endfunction

endpackage

>>> rtl/core/aes_key_expand.sv
`timescale 1ns / 1ps
module aes_key_expand (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [255:0]         key_i,
  output aes_pkg::blk_t        enc_keys_o [aes_pkg::NumKeys],
  output aes_pkg::blk_t        inv_keys_o [aes_pkg::NumKeys],
  output aes_pkg::kx_status_t  status_o
);

  localparam logic [aes_pkg::KeyIdxW-1:0] LastIdx = aes_pkg::KeyIdxW'(aes_pkg::NumRounds);

  logic                        busy_q, busy_d;
  logic [aes_pkg::KeyIdxW-1:0] idx_q, idx_d;
  logic [7:0]                  rc_q, rc_d;
  logic [255:0]                win_q, win_d;
  aes_pkg::blk_t               enc_q [aes_pkg::NumKeys];
  aes_pkg::blk_t               dec_q [aes_pkg::NumKeys];

  logic [31:0]   tw;
  logic [31:0]   n0, n1, n2, n3;
  aes_pkg::blk_t new_key;

  // Next four key words from the last eight
  always_comb begin
    if (!idx_q[0]) begin
      tw = aes_pkg::sub_word({win_q[23:0], win_q[31:24]}) ^ {rc_q, 24'h0};
    end else begin
      tw = aes_pkg::sub_word(win_q[31:0]);
    end
    n0      = win_q[255:224] ^ tw;
    n1      = win_q[223:192] ^ n0;
    n2      = win_q[191:160] ^ n1;
    n3      = win_q[159:128] ^ n2;
    new_key = {n0, n1, n2, n3};
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rc_d   = rc_q;
    win_d  = win_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = aes_pkg::KeyIdxW'(2);
      rc_d   = aes_pkg::RconInit;
      win_d  = key_i;
    end else if (busy_q) begin
      win_d = {win_q[127:0], new_key};
      idx_d = idx_q + 1'b1;
      if (!idx_q[0]) rc_d = aes_pkg::xtime(rc_q);
      if (idx_q == LastIdx) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      rc_q   <= aes_pkg::RconInit;
      win_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      rc_q   <= rc_d;
      win_q  <= win_d;
    end
  end

  // Round key storage; cleared by reset, refilled on each expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < aes_pkg::NumKeys; k++) begin
        enc_q[k] <= '0;
        dec_q[k] <= '0;
      end
    end else if (start_i) begin
      enc_q[0] <= key_i[255:128];
      dec_q[0] <= key_i[255:128];
      enc_q[1] <= key_i[127:0];
      dec_q[1] <= aes_pkg::col_mix(key_i[127:0], aes_pkg::ReqDecrypt);
    end else if (busy_q) begin
      enc_q[idx_q] <= new_key;
      dec_q[idx_q] <= (idx_q == LastIdx) ? new_key
                    : aes_pkg::col_mix(new_key, aes_pkg::ReqDecrypt);
    end
  end

  assign enc_keys_o    = enc_q;
  assign inv_keys_o    = dec_q;
  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (idx_q == LastIdx);

endmodule

>>> rtl/core/aes256_block_cipher_core.sv
`timescale 1ns / 1ps
// AES-256 block engine, 14 rounds, fully pipelined.
// Key: write indexes 0..3 on the cfg channel (valid/ready, index, 64-bit
// data). Index 3 holds the low key bits and starts key expansion;
// cfg_ready_o is low and in_stall_o high while it runs.
// Indexes above 3 are accepted and dropped.
// Input: in_valid_i/in_stall_o with req_type_i (0 encrypt, 1 decrypt) and
// the block in block_high_i/block_low_i. Output: out_valid_o/out_stall_i
// with result_high_o/result_low_o, one result per input, in order.
// Registers: one for the initial key add and one per round. Throughput is
// one block per cycle while out_stall_i is low and no key expansion runs;
// stages 1..14 each hold one round (S-box, column mix, key add; the last
// one skips the mix). A stall holds the last stage and the stall propagates
// back only through occupied stages, so bubbles are squeezed out and no
// transaction is lost or repeated.
// Reset clears the key registers and all round keys to zero; blocks sent
// before the first key write are processed with all-zero round keys.
`include "aes256_block_cipher_core_defines.svh"
module aes256_block_cipher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);

  localparam int unsigned NS = aes_pkg::NumKeys;

  logic [63:0]         key0_q, key1_q, key2_q;
  logic                cfg_wr;
  logic                kx_start;
  aes_pkg::blk_t       enc_keys [NS];
  aes_pkg::blk_t       inv_keys [NS];
  aes_pkg::kx_status_t kx_status;

  logic                in_acc;
  logic [NS-1:0]       vld_q;
  logic [NS-1:0]       typ_q;
  logic [NS-1:0]       rdy;
  aes_pkg::blk_t       st_q [NS];

  // Configuration write channel
  assign cfg_ready_o = !kx_status.busy;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign kx_start    = cfg_wr && (cfg_index_i == aes_pkg::RegKey3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        aes_pkg::RegKey0: key0_q <= cfg_data_i;
        aes_pkg::RegKey1: key1_q <= cfg_data_i;
        aes_pkg::RegKey2: key2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_key_expand u_kx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kx_start),
    .key_i      ({key0_q, key1_q, key2_q, cfg_data_i}),
    .enc_keys_o (enc_keys),
    .inv_keys_o (inv_keys),
    .status_o   (kx_status)
  );

  // Stall chain: a stage takes new data when empty or when its successor moves
  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0] || kx_status.busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 0: initial key add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      typ_q[0] <= req_type_i;
      st_q[0]  <= {block_high_i, block_low_i} ^
                  ((req_type_i == aes_pkg::ReqDecrypt) ? inv_keys[NS-1] : enc_keys[0]);
    end
  end

  // Stages 1..14: one round each
  for (genvar g = 1; g < NS; g++) begin : g_round
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld_q[g] <= vld_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && vld_q[g-1]) begin
        typ_q[g] <= typ_q[g-1];
        st_q[g]  <= aes_pkg::cipher_round(
                      st_q[g-1],
                      (typ_q[g-1] == aes_pkg::ReqDecrypt) ? inv_keys[NS-1-g] : enc_keys[g],
                      typ_q[g-1], (g == NS - 1));
      end
    end
  end

  assign out_valid_o   = vld_q[NS-1];
  assign result_high_o = st_q[NS-1][127:64];
  assign result_low_o  = st_q[NS-1][63:0];

  `AES_ASSERT(a_acc_enters, clk_i, rst_ni, in_acc |=> vld_q[0], "accepted block lost at entry")
  `AES_ASSERT(a_kx_cause, clk_i, rst_ni, $rose(kx_status.busy) |-> $past(kx_start), "expansion without key write")
  `AES_ASSERT(a_kx_blocks_in, clk_i, rst_ni, kx_status.busy |-> !in_acc && !cfg_wr, "accept during expansion")
  `AES_ASSERT(a_kx_ends, clk_i, rst_ni, (kx_status.busy && !kx_status.done) |=> kx_status.busy, "expansion ended early")
  `AES_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> vld_q == '0, "pipeline not empty after reset")

endmodule

>>> tb/aes256_block_cipher_checker.sv
`timescale 1ns / 1ps
// Watches the key, block and result channels of the cipher core, predicts
// each result from its own copy of the key schedule and compares in order.
module aes256_block_cipher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        req_type_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] result_high_i,
  input  logic [63:0] result_low_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic          req;
    aes_pkg::blk_t text;
    logic [63:0]   hi;
    logic [63:0]   lo;
  } cipher_result_t;

  logic [63:0]    key_word [4];
  aes_pkg::blk_t  enc_keys [aes_pkg::NumKeys];
  aes_pkg::blk_t  inv_keys [aes_pkg::NumKeys];
  cipher_result_t result_q [$];
  int             fails;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Byte i = 4*column + row sits at [127-8i -: 8]
  function automatic aes_pkg::blk_t sbox_rotate(aes_pkg::blk_t s, logic inv);
    aes_pkg::blk_t t;
    int   src;
    logic [7:0] b;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? (c - r + 4) % 4 : (c + r) % 4;
        b = s[127-8*(4*src+r) -: 8];
        t[127-8*(4*c+r) -: 8] = inv ? aes_pkg::SBOX_REV[b] : aes_pkg::SBOX[b];
      end
    end
    return t;
  endfunction

  function automatic aes_pkg::blk_t column_mix(aes_pkg::blk_t s, logic inv);
    aes_pkg::blk_t t;
    logic [7:0] m [4];
    logic [7:0] v [4];
    if (inv) begin
      m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    end else begin
      m = '{8'h02, 8'h03, 8'h01, 8'h01};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) v[r] = s[127-8*(4*c+r) -: 8];
      for (int r = 0; r < 4; r++) begin
        // row r uses the coefficients rotated right by r
        t[127-8*(4*c+r) -: 8] = gf_product(v[0], m[(4-r)%4]) ^ gf_product(v[1], m[(5-r)%4])
                              ^ gf_product(v[2], m[(6-r)%4]) ^ gf_product(v[3], m[(7-r)%4]);
      end
    end
    return t;
  endfunction

  function automatic void expand_keys();
    logic [31:0] w [4*aes_pkg::NumKeys];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_word[i][63:32];
      w[2*i+1] = key_word[i][31:0];
    end
    for (int i = 8; i < 4*aes_pkg::NumKeys; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aes_pkg::SBOX[t[31:24]] ^ rc, aes_pkg::SBOX[t[23:16]],
             aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
             aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < aes_pkg::NumKeys; r++) begin
      enc_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      inv_keys[r] = (r == 0 || r == aes_pkg::NumKeys - 1) ? enc_keys[r]
                                                          : column_mix(enc_keys[r], 1'b1);
    end
  endfunction

  function automatic aes_pkg::blk_t cipher(aes_pkg::blk_t s, logic req);
    if (req == aes_pkg::ReqEncrypt) begin
      s ^= enc_keys[0];
      for (int r = 1; r < aes_pkg::NumRounds; r++)
        s = column_mix(sbox_rotate(s, 1'b0), 1'b0) ^ enc_keys[r];
      s = sbox_rotate(s, 1'b0) ^ enc_keys[aes_pkg::NumRounds];
    end else begin
      s ^= inv_keys[aes_pkg::NumRounds];
      for (int r = aes_pkg::NumRounds - 1; r >= 1; r--)
        s = column_mix(sbox_rotate(s, 1'b1), 1'b1) ^ inv_keys[r];
      s = sbox_rotate(s, 1'b1) ^ inv_keys[0];
    end
    return s;
  endfunction

  // Track key writes, predict on block accept, compare on result accept
  always @(posedge clk_i or negedge rst_ni) begin
    cipher_result_t exp_r;
    aes_pkg::blk_t res;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_word[i] = '0;
      for (int r = 0; r < aes_pkg::NumKeys; r++) begin
        enc_keys[r] = '0;
        inv_keys[r] = '0;
      end
      result_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("ERROR: unexpected result %h_%h", result_high_i, result_low_i);
        end else begin
          exp_r = result_q.pop_front();
          if (result_high_i !== exp_r.hi || result_low_i !== exp_r.lo) begin
            fails++;
            if (fails <= 10)
              $display("ERROR: req %0d block %h: expected %h_%h, got %h_%h", exp_r.req,
                       exp_r.text, exp_r.hi, exp_r.lo, result_high_i, result_low_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        res = cipher({block_high_i, block_low_i}, req_type_i);
        result_q.push_back('{req_type_i, {block_high_i, block_low_i}, res[127:64], res[63:0]});
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= aes_pkg::RegKey3) begin
        key_word[cfg_index_i[1:0]] = cfg_data_i;
        if (cfg_index_i == aes_pkg::RegKey3) expand_keys();
      end
    end
  end

endmodule

>>> tb/tb_aes256_block_cipher_core.sv
`timescale 1ns / 1ps
module tb_aes256_block_cipher_core;

  localparam logic [2:0] RegUnused = 3'd5;
  localparam logic [2:0] RegSpare  = 3'd7;
  localparam int         CycleLimit = 300000;
  localparam int         LongHold = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  int fail_count;
  int pending;
  int long_hold_reqs;
  bit sender_quiet;

  aes256_block_cipher_core DUT (.*);

  aes256_block_cipher_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .block_high_i, .block_low_i,
    .out_valid_i(out_valid_o), .out_stall_i, .result_high_i(result_high_o),
    .result_low_i(result_low_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls per transaction, plus requested long holds
  initial begin
    int hold;
    int served;
    bit quiet;
    hold = 0;
    served = 0;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (served < long_hold_reqs) begin
        served++;
        hold = LongHold;
      end else if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 31) == 0) quiet = !quiet;
        hold = quiet ? 0 : $urandom_range(0, 3);
      end
      out_stall_i <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  task automatic write_key_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_block(logic req, logic [63:0] hi, logic [63:0] lo);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    gap = sender_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    block_high_i <= hi;
    block_low_i  <= lo;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3);
    write_key_reg(aes_pkg::RegKey0, k0);
    write_key_reg(aes_pkg::RegKey1, k1);
    write_key_reg(aes_pkg::RegKey2, k2);
    write_key_reg(aes_pkg::RegKey3, k3);
  endtask

  initial begin
    logic [63:0] k [4];
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = aes_pkg::ReqEncrypt;
    block_high_i = '0;
    block_low_i = '0;
    out_stall_i = 1'b0;
    long_hold_reqs = 0;
    sender_quiet = 0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Round keys still zero from reset
    send_block(aes_pkg::ReqEncrypt, '0, '0);
    send_block(aes_pkg::ReqDecrypt, '0, '0);
    send_block(aes_pkg::ReqEncrypt, '1, '1);
    send_block(aes_pkg::ReqDecrypt, '1, '1);
    drain();

    // Low registers alone must not touch the round keys
    write_key_reg(aes_pkg::RegKey0, 64'h0001020304050607);
    write_key_reg(aes_pkg::RegKey1, 64'h08090a0b0c0d0e0f);
    write_key_reg(aes_pkg::RegKey2, 64'h1011121314151617);
    send_block(aes_pkg::ReqEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();
    write_key_reg(aes_pkg::RegKey3, 64'h18191a1b1c1d1e1f);
    write_key_reg(RegUnused, '1);
    write_key_reg(RegSpare, '0);
    send_block(aes_pkg::ReqEncrypt, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(aes_pkg::ReqDecrypt, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    send_block(aes_pkg::ReqEncrypt, '0, '1);
    send_block(aes_pkg::ReqDecrypt, '1, '0);
    send_block(aes_pkg::ReqEncrypt, 64'h8000000000000000, 64'h1);
    send_block(aes_pkg::ReqDecrypt, 64'h1, 64'h8000000000000000);
    drain();

    // Random phases: zero key, all-ones key, then random keys
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 4; i++)
        k[i] = (ph == 0) ? 64'h0 : (ph == 1) ? '1 : {$urandom, $urandom};
      load_key(k[0], k[1], k[2], k[3]);
      if (ph == 3) write_key_reg(RegUnused, {$urandom, $urandom});
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 40) long_hold_reqs++;
        if (ph == 3 && n == 90) drain();
        send_block($urandom_range(0, 1) ? aes_pkg::ReqDecrypt : aes_pkg::ReqEncrypt,
                   {$urandom, $urandom}, {$urandom, $urandom});
      end
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
